>>> rtl/ftar_pkg.sv
// ftar_pkg: shared types and constants for the fragment transfer sender.
// Transaction payload structs, action and mode codes, fragment geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ftar_pkg;

   // Fragment geometry; fragment size must stay a power of two
   localparam int unsigned FRAG_BYTES      = 256;
   localparam int unsigned FRAG_SHIFT      = $clog2(FRAG_BYTES);
   localparam int unsigned MAX_IMAGE_BYTES = 1048576;

   localparam int unsigned MAX_ATTEMPTS = 3;
   localparam logic [15:0] HDR_ACK_INDEX = 16'hFFFF;

   // Request modes
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_ACK    = 2'd2;
   localparam logic [1:0] MODE_CANCEL = 2'd3;

   // Response actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_HEADER  = 3'd1;
   localparam logic [2:0] ACT_FRAG    = 3'd2;
   localparam logic [2:0] ACT_SUCCESS = 3'd3;
   localparam logic [2:0] ACT_FAILURE = 3'd4;
   localparam logic [2:0] ACT_REFUSED = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_ACK_ENABLED      = 2'd0;
   localparam logic [1:0] CSR_RETRY_ENABLED    = 2'd1;
   localparam logic [1:0] CSR_CHECKSUM_ENABLED = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS    = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [20:0] image_size;
      logic        ack_marker_ok;
      logic [15:0] ack_index;
      logic [7:0]  ack_status;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [11:0] frag_index;
      logic [19:0] frag_offset;
      logic [8:0]  frag_size;
      logic        frag_last;
      logic [12:0] total_frags;
      logic [2:0]  header_flags;
      logic        busy_res;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/fragment_transfer_ack_retry.sv
// Request register, then response register. Throughput: one transaction
// per cycle unless rsp_ready stalls; the request register holds one
// transaction while a finished response waits in the response register.
// Reset: synchronous, active high; transfer idle, ack/retry/checksum enabled,
// timeout 1000 ticks.
// Stop-and-wait fragment sender; depends on ftar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fragment_transfer_ack_retry (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire ftar_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ftar_pkg::rsp_type     rsp_data,
   input  wire                   csr_write,
   input  wire  [1:0]            csr_index,
   input  wire  [15:0]           csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SEND_HDR, PH_WAIT_HDR, PH_SEND_FRAG,
      PH_WAIT_FRAG, PH_RETRY_FRAG, PH_DONE, PH_ERROR
   } phase_type;

   localparam logic [16:0] WAIT_MAX = 17'h1FFFF;

   // configuration
   logic        ack_en_ff, retry_en_ff, csum_en_ff;
   logic [15:0] timeout_ff;

   // pipeline
   logic              in_valid_ff;
   ftar_pkg::req_type in_ff;
   logic              out_valid_ff;
   ftar_pkg::rsp_type out_ff;
   logic              move;

   // transfer state
   phase_type   phase_ff, phase_in;
   logic [11:0] cur_frag_ff, cur_frag_in;
   logic [12:0] frag_count_ff, frag_count_in;
   logic [20:0] image_bytes_ff, image_bytes_in;
   logic [1:0]  retry_ff, retry_in;
   logic [16:0] wait_ff, wait_in;
   ftar_pkg::rsp_type rsp_in;

   // fragment geometry for the current fragment
   logic [20:0] frag_off;
   logic [21:0] frag_end;
   logic [8:0]  frag_size;
   logic        frag_last;
   logic [12:0] next_frag;
   logic        last_reached;
   logic [16:0] wait_sat;
   logic        timed_out;
   logic [1:0]  retry_inc;
   logic        retry_exhausted;
   logic [2:0]  hdr_flags;
   logic [12:0] start_count;
   logic        start_bad;

   assign move      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign frag_off  = 21'(cur_frag_ff) << ftar_pkg::FRAG_SHIFT;
   assign frag_end  = 22'(frag_off) + 22'(ftar_pkg::FRAG_BYTES);
   assign frag_size = (frag_end > 22'(image_bytes_ff))
                      ? ((frag_off < image_bytes_ff) ? 9'(image_bytes_ff - frag_off) : 9'd0)
                      : 9'(ftar_pkg::FRAG_BYTES);
   assign frag_last = (frag_count_ff != 13'd0)
                      && (13'(cur_frag_ff) == frag_count_ff - 13'd1);
   assign next_frag    = 13'(cur_frag_ff) + 13'd1;
   assign last_reached = next_frag >= frag_count_ff;

   assign wait_sat  = (wait_ff < WAIT_MAX) ? wait_ff + 17'd1 : wait_ff;
   assign timed_out = wait_sat > 17'(timeout_ff);
   assign retry_inc = retry_ff + 2'd1;
   assign retry_exhausted = 32'(retry_inc) >= ftar_pkg::MAX_ATTEMPTS;
   assign hdr_flags = {retry_en_ff, csum_en_ff, ack_en_ff};

   assign start_count = 13'((22'(in_ff.image_size) + 22'(ftar_pkg::FRAG_BYTES - 1))
                            >> ftar_pkg::FRAG_SHIFT);
   assign start_bad   = (phase_ff != PH_IDLE) || (in_ff.image_size == 21'd0)
                        || (22'(in_ff.image_size) > 22'(ftar_pkg::MAX_IMAGE_BYTES));

   always_comb begin
      phase_in       = phase_ff;
      cur_frag_in    = cur_frag_ff;
      frag_count_in  = frag_count_ff;
      image_bytes_in = image_bytes_ff;
      retry_in       = retry_ff;
      wait_in        = wait_ff;
      rsp_in         = '0;
      rsp_in.action  = ftar_pkg::ACT_NONE;

      case (in_ff.mode)
         ftar_pkg::MODE_TICK: begin
            case (phase_ff)
               PH_SEND_HDR: begin
                  if (ack_en_ff) begin
                     phase_in = PH_WAIT_HDR;
                     wait_in  = '0;
                  end else begin
                     phase_in = PH_SEND_FRAG;
                  end
               end
               PH_WAIT_HDR: begin
                  wait_in = wait_sat;
                  if (timed_out) begin
                     retry_in = retry_inc;
                     if (retry_exhausted) begin
                        phase_in = PH_ERROR;
                     end else begin
                        phase_in            = PH_SEND_HDR;
                        rsp_in.action       = ftar_pkg::ACT_HEADER;
                        rsp_in.total_frags  = frag_count_ff;
                        rsp_in.header_flags = hdr_flags;
                     end
                  end
               end
               PH_SEND_FRAG, PH_RETRY_FRAG: begin
                  rsp_in.action      = ftar_pkg::ACT_FRAG;
                  rsp_in.frag_index  = cur_frag_ff;
                  rsp_in.frag_offset = frag_off[19:0];
                  rsp_in.frag_size   = frag_size;
                  rsp_in.frag_last   = frag_last;
                  if (ack_en_ff) begin
                     phase_in = PH_WAIT_FRAG;
                     wait_in  = '0;
                  end else if (last_reached) begin
                     phase_in = PH_DONE;
                  end else begin
                     cur_frag_in = next_frag[11:0];
                     phase_in    = PH_SEND_FRAG;
                  end
               end
               PH_WAIT_FRAG: begin
                  wait_in = wait_sat;
                  if (timed_out) begin
                     retry_in = retry_inc;
                     if (retry_exhausted) begin
                        phase_in = PH_ERROR;
                     end else begin
                        rsp_in.action      = ftar_pkg::ACT_FRAG;
                        rsp_in.frag_index  = cur_frag_ff;
                        rsp_in.frag_offset = frag_off[19:0];
                        rsp_in.frag_size   = frag_size;
                        rsp_in.frag_last   = frag_last;
                        wait_in            = '0;
                     end
                  end
               end
               PH_DONE, PH_ERROR: begin
                  phase_in       = PH_IDLE;
                  cur_frag_in    = '0;
                  frag_count_in  = '0;
                  image_bytes_in = '0;
                  retry_in       = '0;
                  wait_in        = '0;
                  rsp_in.action  = (phase_ff == PH_DONE) ? ftar_pkg::ACT_SUCCESS
                                                         : ftar_pkg::ACT_FAILURE;
               end
               default: begin
               end
            endcase
         end
         ftar_pkg::MODE_START: begin
            if (start_bad) begin
               rsp_in.action = ftar_pkg::ACT_REFUSED;
            end else begin
               image_bytes_in      = in_ff.image_size;
               frag_count_in       = start_count;
               cur_frag_in         = '0;
               retry_in            = '0;
               wait_in             = '0;
               phase_in            = PH_SEND_HDR;
               rsp_in.action       = ftar_pkg::ACT_HEADER;
               rsp_in.total_frags  = start_count;
               rsp_in.header_flags = hdr_flags;
            end
         end
         ftar_pkg::MODE_ACK: begin
            if (ack_en_ff && in_ff.ack_marker_ok) begin
               if (phase_ff == PH_WAIT_HDR) begin
                  if (in_ff.ack_index == ftar_pkg::HDR_ACK_INDEX
                      && in_ff.ack_status == 8'd0) begin
                     phase_in = PH_SEND_FRAG;
                     retry_in = '0;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end else if (phase_ff == PH_WAIT_FRAG
                            && in_ff.ack_index == 16'(cur_frag_ff)) begin
                  if (in_ff.ack_status == 8'd0) begin
                     retry_in = '0;
                     if (last_reached) begin
                        phase_in = PH_DONE;
                     end else begin
                        cur_frag_in = next_frag[11:0];
                        phase_in    = PH_SEND_FRAG;
                     end
                  end else if (retry_en_ff) begin
                     retry_in = retry_inc;
                     phase_in = retry_exhausted ? PH_ERROR : PH_RETRY_FRAG;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
            end
         end
         ftar_pkg::MODE_CANCEL: begin
            phase_in       = PH_IDLE;
            cur_frag_in    = '0;
            frag_count_in  = '0;
            image_bytes_in = '0;
            retry_in       = '0;
            wait_in        = '0;
         end
         default: begin
         end
      endcase

      rsp_in.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_en_ff      <= 1'b1;
         retry_en_ff    <= 1'b1;
         csum_en_ff     <= 1'b1;
         timeout_ff     <= ftar_pkg::TIMEOUT_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         cur_frag_ff    <= '0;
         frag_count_ff  <= '0;
         image_bytes_ff <= '0;
         retry_ff       <= '0;
         wait_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ftar_pkg::CSR_ACK_ENABLED:      ack_en_ff   <= csr_data[0];
               ftar_pkg::CSR_RETRY_ENABLED:    retry_en_ff <= csr_data[0];
               ftar_pkg::CSR_CHECKSUM_ENABLED: csum_en_ff  <= csr_data[0];
               ftar_pkg::CSR_TIMEOUT_TICKS:    timeout_ff  <= csr_data;
               default: begin
               end
            endcase
         end

         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end

         if (move) begin
            out_valid_ff   <= 1'b1;
            phase_ff       <= phase_in;
            cur_frag_ff    <= cur_frag_in;
            frag_count_ff  <= frag_count_in;
            image_bytes_ff <= image_bytes_in;
            retry_ff       <= retry_in;
            wait_ff        <= wait_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (move) begin
         out_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cur_frag_ff == 12'd0 && frag_count_ff == 13'd0)
      else $error("idle phase with stale transfer state");

   a_frag_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> frag_count_ff != 13'd0 && 13'(cur_frag_ff) < frag_count_ff)
      else $error("current fragment outside transfer");

   a_retry_limit: assert property (@(posedge clock) disable iff (reset)
      retry_ff == 2'd3 |-> phase_ff == PH_ERROR)
      else $error("attempt limit reached without error phase");

   a_end_not_busy: assert property (@(posedge clock) disable iff (reset)
      move && (rsp_in.action == ftar_pkg::ACT_SUCCESS
               || rsp_in.action == ftar_pkg::ACT_FAILURE)
      |=> phase_ff == PH_IDLE && !out_ff.busy_res)
      else $error("transfer end reported while still busy");
`endif

endmodule
`default_nettype wire

>>> sim/tb_fragment_transfer_ack_retry.sv
// Self-checking testbench for fragment_transfer_ack_retry: directed and random transactions,
// with responses checked against an in-bench model of the stop-and-wait sender.
// Depends on ftar_pkg and the fragment_transfer_ack_retry RTL.
`timescale 1ns / 1ps
module tb_fragment_transfer_ack_retry;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      XF_IDLE, XF_SEND_HDR, XF_WAIT_HDR, XF_SEND_FRAG,
      XF_WAIT_FRAG, XF_RETRY_FRAG, XF_DONE, XF_ERROR
   } xfer_phase_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ftar_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ftar_pkg::rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = ftar_pkg::CSR_ACK_ENABLED;
   logic [15:0] csr_data = '0;

   fragment_transfer_ack_retry u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Sender model state and its copy of the configuration
   xfer_phase_type xf_phase;
   logic [11:0] cur_frag;
   logic [12:0] n_frags;
   logic [20:0] img_bytes;
   logic [1:0]  attempts;
   logic [16:0] wait_cnt;
   logic        cfg_ack, cfg_retry, cfg_csum;
   logic [15:0] cfg_timeout;

   ftar_pkg::rsp_type expected_rsps[$];
   int unsigned err_count = 0;
   int unsigned rsp_count = 0;
   int unsigned cycle_count = 0;
   bit          sender_idle_on = 1'b0;
   bit          receiver_idle_on = 1'b0;
   int unsigned rsp_hold_request = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_xfer();
      xf_phase  = XF_IDLE;
      cur_frag  = '0;
      n_frags   = '0;
      img_bytes = '0;
      attempts  = '0;
      wait_cnt  = '0;
   endfunction

   function automatic void fill_header(inout ftar_pkg::rsp_type o);
      o.action       = ftar_pkg::ACT_HEADER;
      o.total_frags  = n_frags;
      o.header_flags = {cfg_retry, cfg_csum, cfg_ack};
   endfunction

   function automatic void fill_fragment(inout ftar_pkg::rsp_type o);
      int unsigned off, sz;
      off = cur_frag * ftar_pkg::FRAG_BYTES;
      sz  = ftar_pkg::FRAG_BYTES;
      if (off + sz > img_bytes)
         sz = (off < img_bytes) ? img_bytes - off : 0;
      o.action      = ftar_pkg::ACT_FRAG;
      o.frag_index  = cur_frag;
      o.frag_offset = off[19:0];
      o.frag_size   = sz[8:0];
      o.frag_last   = (n_frags != 0) && ({1'b0, cur_frag} == n_frags - 13'd1);
   endfunction

   // Saturating wait counter; true once the timeout is exceeded
   function automatic bit wait_expired();
      if (wait_cnt != 17'h1FFFF) wait_cnt = wait_cnt + 17'd1;
      return wait_cnt > {1'b0, cfg_timeout};
   endfunction

   function automatic void next_fragment();
      logic [12:0] nxt;
      nxt = {1'b0, cur_frag} + 13'd1;
      if (nxt >= n_frags) begin
         xf_phase = XF_DONE;
      end else begin
         cur_frag = nxt[11:0];
         xf_phase = XF_SEND_FRAG;
      end
   endfunction

   function automatic ftar_pkg::rsp_type sender_step(input ftar_pkg::req_type r);
      ftar_pkg::rsp_type o;
      int unsigned       nf;
      o = '0;
      case (r.mode)
         ftar_pkg::MODE_TICK: begin
            case (xf_phase)
               XF_SEND_HDR: begin
                  if (cfg_ack) begin
                     xf_phase = XF_WAIT_HDR;
                     wait_cnt = '0;
                  end else begin
                     xf_phase = XF_SEND_FRAG;
                  end
               end
               XF_WAIT_HDR: begin
                  if (wait_expired()) begin
                     attempts = attempts + 2'd1;
                     if (attempts >= ftar_pkg::MAX_ATTEMPTS) begin
                        xf_phase = XF_ERROR;
                     end else begin
                        xf_phase = XF_SEND_HDR;
                        fill_header(o);
                     end
                  end
               end
               XF_SEND_FRAG, XF_RETRY_FRAG: begin
                  fill_fragment(o);
                  if (cfg_ack) begin
                     xf_phase = XF_WAIT_FRAG;
                     wait_cnt = '0;
                  end else begin
                     next_fragment();
                  end
               end
               XF_WAIT_FRAG: begin
                  if (wait_expired()) begin
                     attempts = attempts + 2'd1;
                     if (attempts >= ftar_pkg::MAX_ATTEMPTS) begin
                        xf_phase = XF_ERROR;
                     end else begin
                        fill_fragment(o);
                        wait_cnt = '0;
                     end
                  end
               end
               XF_DONE: begin
                  clear_xfer();
                  o.action = ftar_pkg::ACT_SUCCESS;
               end
               XF_ERROR: begin
                  clear_xfer();
                  o.action = ftar_pkg::ACT_FAILURE;
               end
               default: ;
            endcase
         end
         ftar_pkg::MODE_START: begin
            if (xf_phase != XF_IDLE || r.image_size == 0
                || r.image_size > ftar_pkg::MAX_IMAGE_BYTES) begin
               o.action = ftar_pkg::ACT_REFUSED;
            end else begin
               nf        = (r.image_size + ftar_pkg::FRAG_BYTES - 1) / ftar_pkg::FRAG_BYTES;
               img_bytes = r.image_size;
               n_frags   = nf[12:0];
               cur_frag  = '0;
               attempts  = '0;
               wait_cnt  = '0;
               xf_phase  = XF_SEND_HDR;
               fill_header(o);
            end
         end
         ftar_pkg::MODE_ACK: begin
            if (cfg_ack && r.ack_marker_ok) begin
               if (xf_phase == XF_WAIT_HDR) begin
                  if (r.ack_index == ftar_pkg::HDR_ACK_INDEX && r.ack_status == 0) begin
                     xf_phase = XF_SEND_FRAG;
                     attempts = '0;
                  end else begin
                     xf_phase = XF_ERROR;
                  end
               end else if (xf_phase == XF_WAIT_FRAG && r.ack_index == {4'd0, cur_frag}) begin
                  if (r.ack_status == 0) begin
                     attempts = '0;
                     next_fragment();
                  end else if (cfg_retry) begin
                     attempts = attempts + 2'd1;
                     xf_phase = (attempts >= ftar_pkg::MAX_ATTEMPTS) ? XF_ERROR
                                                                     : XF_RETRY_FRAG;
                  end else begin
                     xf_phase = XF_ERROR;
                  end
               end
            end
         end
         default: clear_xfer();
      endcase
      o.busy_res = (xf_phase != XF_IDLE);
      return o;
   endfunction

   function automatic ftar_pkg::req_type mk_req(input logic [1:0] m,
                                                input logic [20:0] size = '0,
                                                input logic mk = 1'b0,
                                                input logic [15:0] idx = '0,
                                                input logic [7:0] st = '0);
      ftar_pkg::req_type r;
      r.mode          = m;
      r.image_size    = size;
      r.ack_marker_ok = mk;
      r.ack_index     = idx;
      r.ack_status    = st;
      return r;
   endfunction

   function automatic logic [20:0] pick_image_size();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 70) return 21'($urandom_range(1, 1024));
      if (p < 85) return 21'($urandom_range(1025, 4096));
      if (p < 90) return '0;
      if (p < 95) return 21'($urandom_range(ftar_pkg::MAX_IMAGE_BYTES + 1, 21'h1FFFFF));
      return 21'($urandom_range(1, ftar_pkg::MAX_IMAGE_BYTES));
   endfunction

   // Mostly well-formed transfer traffic steered by the model phase, plus noise
   function automatic ftar_pkg::req_type next_random_req();
      ftar_pkg::req_type r;
      int unsigned       p;
      r.mode          = 2'($urandom);
      r.image_size    = 21'($urandom);
      r.ack_marker_ok = 1'($urandom);
      r.ack_index     = 16'($urandom);
      r.ack_status    = 8'($urandom);
      p = $urandom_range(0, 99);
      if (p < 3) begin
         r.mode = ftar_pkg::MODE_CANCEL;
      end else if (p >= 8) begin
         p = $urandom_range(0, 99);
         r.mode = ftar_pkg::MODE_TICK;
         case (xf_phase)
            XF_IDLE: begin
               if (p < 70) begin
                  r.mode       = ftar_pkg::MODE_START;
                  r.image_size = pick_image_size();
               end
            end
            XF_WAIT_HDR: begin
               if (p < 55) begin
                  r.mode          = ftar_pkg::MODE_ACK;
                  r.ack_marker_ok = ($urandom_range(0, 9) != 0);
                  r.ack_index     = ($urandom_range(0, 9) != 0) ? ftar_pkg::HDR_ACK_INDEX
                                                                : 16'($urandom);
                  r.ack_status    = ($urandom_range(0, 9) != 0) ? 8'd0
                                                                : 8'($urandom_range(1, 255));
               end
            end
            XF_WAIT_FRAG: begin
               if (p < 55) begin
                  r.mode          = ftar_pkg::MODE_ACK;
                  r.ack_marker_ok = ($urandom_range(0, 9) != 0);
                  r.ack_index     = ($urandom_range(0, 9) != 0) ? {4'd0, cur_frag}
                                                                : 16'($urandom);
                  r.ack_status    = ($urandom_range(0, 4) != 0) ? 8'd0
                                                                : 8'($urandom_range(1, 255));
               end
            end
            default: begin
               if (p < 10) r.mode = ftar_pkg::MODE_START;
            end
         endcase
      end
      return r;
   endfunction

   task automatic send_req(input ftar_pkg::req_type r);
      int unsigned gap;
      gap = sender_idle_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(sender_step(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles; the block must be idle
   task automatic set_config(input logic ack, input logic retry, input logic csum,
                             input logic [15:0] tmo);
      csr_write <= 1'b1;
      csr_index <= ftar_pkg::CSR_ACK_ENABLED;
      csr_data  <= {15'($urandom), ack};
      @(posedge clock);
      csr_index <= ftar_pkg::CSR_RETRY_ENABLED;
      csr_data  <= {15'($urandom), retry};
      @(posedge clock);
      csr_index <= ftar_pkg::CSR_CHECKSUM_ENABLED;
      csr_data  <= {15'($urandom), csum};
      @(posedge clock);
      csr_index <= ftar_pkg::CSR_TIMEOUT_TICKS;
      csr_data  <= tmo;
      @(posedge clock);
      csr_write   <= 1'b0;
      cfg_ack     = ack;
      cfg_retry   = retry;
      cfg_csum    = csum;
      cfg_timeout = tmo;
   endtask

   task automatic test_start_and_refusal();
      send_req(mk_req(ftar_pkg::MODE_TICK));
      send_req(mk_req(ftar_pkg::MODE_START, 21'd0));
      send_req(mk_req(ftar_pkg::MODE_START, 21'h1FFFFF));
      send_req(mk_req(ftar_pkg::MODE_START, 21'(ftar_pkg::MAX_IMAGE_BYTES)));
      send_req(mk_req(ftar_pkg::MODE_START, 21'd5));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, 16'd0, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_CANCEL));
      send_req(mk_req(ftar_pkg::MODE_TICK));
   endtask

   // Header ack, a negative fragment status with retry, then completion
   task automatic test_acked_transfer();
      send_req(mk_req(ftar_pkg::MODE_START, 21'd300));
      send_req(mk_req(ftar_pkg::MODE_TICK));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b0, ftar_pkg::HDR_ACK_INDEX, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, ftar_pkg::HDR_ACK_INDEX, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_TICK));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, 16'd7, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, 16'd0, 8'hFF));
      send_req(mk_req(ftar_pkg::MODE_TICK));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, 16'd0, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_TICK));
      send_req(mk_req(ftar_pkg::MODE_ACK, 21'd0, 1'b1, 16'd1, 8'd0));
      send_req(mk_req(ftar_pkg::MODE_TICK));
   endtask

   // Zero timeout: every wait tick expires, header resent until failure
   task automatic test_header_timeout();
      int i;
      wait_idle();
      set_config(1'b1, 1'b1, 1'b0, 16'd0);
      send_req(mk_req(ftar_pkg::MODE_START, 21'd1));
      for (i = 0; i < 7; i++) send_req(mk_req(ftar_pkg::MODE_TICK));
   endtask

   task automatic run_random_phase(input logic ack, input logic retry, input logic csum,
                                   input logic [15:0] tmo, input int n,
                                   input bit s_idle, input bit r_idle);
      int i;
      wait_idle();
      set_config(ack, retry, csum, tmo);
      sender_idle_on   = s_idle;
      receiver_idle_on = r_idle;
      for (i = 0; i < n; i++) send_req(next_random_req());
   endtask

   task automatic test_random_configs();
      run_random_phase(1'b1, 1'b1, 1'b1, 16'd3,     160, 1'b1, 1'b1);
      run_random_phase(1'b1, 1'b1, 1'b0, 16'd0,     140, 1'b1, 1'b1);
      run_random_phase(1'b1, 1'b0, 1'b1, 16'd2,     140, 1'b1, 1'b0);
      run_random_phase(1'b0, 1'b1, 1'b1, 16'hFFFF,  120, 1'b0, 1'b1);
      run_random_phase(1'b0, 1'b0, 1'b0, 16'd1,     100, 1'b0, 1'b0);
      run_random_phase(1'b1, 1'b1, 1'b1, 16'd1000,  120, 1'b1, 1'b1);
      run_random_phase(1'b1, 1'b1, 1'b1, 16'd1,     140, 1'b1, 1'b1);
      run_random_phase(1'($urandom), 1'($urandom), 1'($urandom),
                       16'($urandom_range(0, 4)), 100, 1'b1, 1'b1);
   endtask

   // Long receiver stall fills the block; then the sender waits for a full drain
   task automatic test_backpressure();
      int i;
      wait_idle();
      set_config(1'b1, 1'b1, 1'b1, 16'd2);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b1;
      rsp_hold_request = 80;
      for (i = 0; i < 24; i++) send_req(next_random_req());
      wait_idle();
      sender_idle_on = 1'b1;
      for (i = 0; i < 16; i++) send_req(next_random_req());
   endtask

   // Response sink: per-transaction random stall, or one long hold-off on request
   initial begin : rsp_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready && receiver_idle_on) begin
            stall_left = $urandom_range(0, 11);
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= 10)
            $display("response %0d: %s expected %0d, got %0d", rsp_count, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      ftar_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("response %0d: unexpected transaction, action %0d",
                        rsp_count, rsp_data.action);
         end else begin
            want = expected_rsps.pop_front();
            check_field("action",       want.action,       rsp_data.action);
            check_field("frag_index",   want.frag_index,   rsp_data.frag_index);
            check_field("frag_offset",  want.frag_offset,  rsp_data.frag_offset);
            check_field("frag_size",    want.frag_size,    rsp_data.frag_size);
            check_field("frag_last",    want.frag_last,    rsp_data.frag_last);
            check_field("total_frags",  want.total_frags,  rsp_data.total_frags);
            check_field("header_flags", want.header_flags, rsp_data.header_flags);
            check_field("busy_res",     want.busy_res,     rsp_data.busy_res);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      clear_xfer();
      cfg_ack     = 1'b1;
      cfg_retry   = 1'b1;
      cfg_csum    = 1'b1;
      cfg_timeout = ftar_pkg::TIMEOUT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_start_and_refusal();
      test_acked_transfer();
      test_header_timeout();
      test_random_configs();
      test_backpressure();
      wait_idle();
      repeat (10) @(posedge clock);
      if (err_count == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
